/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on the rising edge and disabled
// while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* src/dsog_pkg.sv */
// ----------------------------------------------------------------------------
// dsog_pkg
// Shared types and constants of the dual sonar obstacle guard.
// ----------------------------------------------------------------------------
`default_nettype none

package dsog_pkg;

  localparam int DIST_W = 11;
  localparam int THR_W  = 10;
  localparam int MS_W   = 16;
  localparam int HIST_D = 3;
  localparam int SLOT_W = 2;

  localparam logic [DIST_W-1:0] DIST_NONE     = 11'h7FF;
  localparam logic [THR_W-1:0]  THR_RESET     = 10'd20;
  localparam logic [MS_W-1:0]   PERIOD_RESET  = 16'd50;
  localparam logic [MS_W-1:0]   WARMUP_RESET  = 16'd3000;
  localparam logic [MS_W-1:0]   MS_MAX        = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_PERIOD    = 2'd1,
    REG_WARMUP    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic              wr;
    logic [SLOT_W-1:0] slot;
  } lane_ctl_t;

  typedef struct packed {
    logic [DIST_W-1:0] filt_new;
    logic              near_new;
    logic              near_last;
    logic [DIST_W-1:0] filt_q;
  } lane_res_t;

  typedef struct packed {
    logic triggered;
    logic emergency;
    logic obstacle;
    logic sample_due;
  } flags_t;

endpackage

`default_nettype wire

/* src/dsog_lane.sv */
// ----------------------------------------------------------------------------
// dsog_lane
// One sensor channel: three-entry history, median of valid entries and the
// threshold test on the new and the held filtered distance.
// ----------------------------------------------------------------------------
`default_nettype none

module dsog_lane (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dsog_pkg::lane_ctl_t         ctl_i,
  input  wire logic [dsog_pkg::DIST_W-1:0] dist_i,
  input  wire logic [dsog_pkg::THR_W-1:0]  thr_i,
  output dsog_pkg::lane_res_t              res_o
);

  logic [dsog_pkg::DIST_W-1:0] hist_q [dsog_pkg::HIST_D];
  logic [dsog_pkg::DIST_W-1:0] hist_n [dsog_pkg::HIST_D];
  logic [dsog_pkg::DIST_W-1:0] filt_q;
  logic [dsog_pkg::HIST_D-1:0] valid;
  logic [dsog_pkg::THR_W-1:0]  v [dsog_pkg::HIST_D];
  logic [dsog_pkg::THR_W-1:0]  lo, hi, med;
  logic [dsog_pkg::THR_W:0]    pair_sum;
  logic                        any_valid;
  logic [dsog_pkg::DIST_W-1:0] filt_new;

  always_comb begin
    for (int i = 0; i < dsog_pkg::HIST_D; i++) begin
      hist_n[i] = hist_q[i];
      if (ctl_i.wr && ctl_i.slot == dsog_pkg::SLOT_W'(i)) begin
        hist_n[i] = dist_i;
      end
      valid[i] = !hist_n[i][dsog_pkg::DIST_W-1] && (|hist_n[i][dsog_pkg::THR_W-1:0]);
      v[i]     = hist_n[i][dsog_pkg::THR_W-1:0];
    end
  end

  always_comb begin
    lo        = (v[0] < v[1]) ? v[0] : v[1];
    hi        = (v[0] < v[1]) ? v[1] : v[0];
    pair_sum  = '0;
    med       = '0;
    any_valid = 1'b1;
    case (valid)
      3'b001: med = v[0];
      3'b010: med = v[1];
      3'b100: med = v[2];
      3'b011: pair_sum = {1'b0, v[0]} + {1'b0, v[1]};
      3'b101: pair_sum = {1'b0, v[0]} + {1'b0, v[2]};
      3'b110: pair_sum = {1'b0, v[1]} + {1'b0, v[2]};
      3'b111: begin
        if (v[2] <= lo) begin
          med = lo;
        end else if (v[2] >= hi) begin
          med = hi;
        end else begin
          med = v[2];
        end
      end
      default: any_valid = 1'b0;
    endcase
    if (valid == 3'b011 || valid == 3'b101 || valid == 3'b110) begin
      med = pair_sum[dsog_pkg::THR_W:1];
    end
    filt_new = any_valid ? {1'b0, med} : dsog_pkg::DIST_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dsog_pkg::HIST_D; i++) begin
        hist_q[i] <= dsog_pkg::DIST_NONE;
      end
      filt_q <= dsog_pkg::DIST_NONE;
    end else if (ctl_i.wr) begin
      for (int i = 0; i < dsog_pkg::HIST_D; i++) begin
        hist_q[i] <= hist_n[i];
      end
      filt_q <= filt_new;
    end
  end

  assign res_o.filt_new  = filt_new;
  assign res_o.near_new  = any_valid && (med <= thr_i);
  assign res_o.near_last = !filt_q[dsog_pkg::DIST_W-1] && (|filt_q[dsog_pkg::THR_W-1:0])
                           && (filt_q[dsog_pkg::THR_W-1:0] <= thr_i);
  assign res_o.filt_q    = filt_q;

endmodule

`default_nettype wire

/* src/dsog_ctrl.sv */
// ----------------------------------------------------------------------------
// dsog_ctrl
// Merge stage: warm-up and period counters, history slot, obstacle
// hysteresis and the emergency and stop flags.
// ----------------------------------------------------------------------------
`default_nettype none

module dsog_ctrl #(
  parameter int TRIGGER_COUNT = 2,
  parameter int RELEASE_COUNT = 2
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      acc_i,
  input  wire dsog_pkg::action_e         action_i,
  input  wire logic                      button_i,
  input  wire logic                      near_new_i,
  input  wire logic                      near_last_i,
  input  wire logic [dsog_pkg::MS_W-1:0] period_cfg_i,
  input  wire logic [dsog_pkg::MS_W-1:0] warmup_cfg_i,
  output dsog_pkg::lane_ctl_t            ctl_o,
  output dsog_pkg::flags_t               flags_o
);

  localparam int TRIG_W = $clog2(TRIGGER_COUNT + 1);
  localparam int REL_W  = $clog2(RELEASE_COUNT + 1);

  logic [dsog_pkg::MS_W-1:0]   warm_q, warm_d;
  logic [dsog_pkg::MS_W-1:0]   period_q, period_d;
  logic [dsog_pkg::SLOT_W-1:0] slot_q, slot_d, slot_cur;
  logic [TRIG_W-1:0]           near_cnt_q, near_cnt_d;
  logic [REL_W-1:0]            far_cnt_q, far_cnt_d;
  logic                        obs_q, obs_d;
  logic                        emg_q, emg_d;
  logic                        stop_q, stop_d;
  logic                        sample_wr;

  assign slot_cur = (slot_q >= dsog_pkg::SLOT_W'(dsog_pkg::HIST_D)) ? '0 : slot_q;

  always_comb begin
    warm_d     = warm_q;
    period_d   = period_q;
    slot_d     = slot_q;
    near_cnt_d = near_cnt_q;
    far_cnt_d  = far_cnt_q;
    obs_d      = obs_q;
    emg_d      = emg_q;
    stop_d     = stop_q;
    sample_wr  = 1'b0;
    if (acc_i) begin
      case (action_i)
        dsog_pkg::ACT_TICK: begin
          if (warm_q != dsog_pkg::MS_MAX) begin
            warm_d = warm_q + 1'b1;
          end
          if (period_q != dsog_pkg::MS_MAX) begin
            period_d = period_q + 1'b1;
          end
          emg_d  = button_i;
          stop_d = button_i || obs_q;
        end
        dsog_pkg::ACT_SAMPLE: begin
          sample_wr = 1'b1;
          period_d  = '0;
          emg_d     = button_i;
          slot_d    = (slot_cur == dsog_pkg::SLOT_W'(dsog_pkg::HIST_D - 1)) ? '0
                                                                           : slot_cur + 1'b1;
          if (warm_q >= warmup_cfg_i) begin
            if (near_new_i) begin
              if (near_cnt_q < TRIG_W'(TRIGGER_COUNT)) begin
                near_cnt_d = near_cnt_q + 1'b1;
              end
              far_cnt_d = '0;
            end else begin
              if (far_cnt_q < REL_W'(RELEASE_COUNT)) begin
                far_cnt_d = far_cnt_q + 1'b1;
              end
              near_cnt_d = '0;
            end
            if (near_cnt_d >= TRIG_W'(TRIGGER_COUNT)) begin
              obs_d = 1'b1;
            end else if (far_cnt_d >= REL_W'(RELEASE_COUNT)) begin
              obs_d = 1'b0;
            end
          end else begin
            obs_d      = 1'b0;
            near_cnt_d = '0;
            far_cnt_d  = '0;
          end
          stop_d = button_i || obs_d;
        end
        dsog_pkg::ACT_CLEAR: begin
          if (!button_i && !near_last_i) begin
            stop_d = 1'b0;
            emg_d  = 1'b0;
            obs_d  = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q     <= '0;
      period_q   <= '0;
      slot_q     <= '0;
      near_cnt_q <= '0;
      far_cnt_q  <= '0;
      obs_q      <= 1'b0;
      emg_q      <= 1'b0;
      stop_q     <= 1'b0;
    end else begin
      warm_q     <= warm_d;
      period_q   <= period_d;
      slot_q     <= slot_d;
      near_cnt_q <= near_cnt_d;
      far_cnt_q  <= far_cnt_d;
      obs_q      <= obs_d;
      emg_q      <= emg_d;
      stop_q     <= stop_d;
    end
  end

  assign ctl_o.wr           = sample_wr;
  assign ctl_o.slot         = slot_cur;
  assign flags_o.triggered  = stop_d;
  assign flags_o.emergency  = emg_d;
  assign flags_o.obstacle   = obs_d;
  assign flags_o.sample_due = period_d >= period_cfg_i;

endmodule

`default_nettype wire

/* src/dual_sonar_obstacle_guard.sv */
// ----------------------------------------------------------------------------
// dual_sonar_obstacle_guard
// Two sonar lanes filter their distances side by side; the control stage
// merges them into the obstacle hysteresis and the stop flags.
//
//   channel   direction  handshake                  word
//   s_axis    in         s_axis_tvalid/tready       action, distances, button
//   m_axis    out        m_axis_tvalid/tready       flags, filtered distances
//   cfg       in         cfg_valid_i/cfg_ready_o    register index and value
//
// One word per cycle while s_axis_tready is high; its result is in the output register in the next cycle.
// The lane median, threshold test and hysteresis update form a single stage.
// Reset is asynchronous and returns every register but m_data_q to its reset value.
// Input is held off only while a result waits and m_axis_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dual_sonar_obstacle_guard #(
  parameter int TRIGGER_COUNT = 2,
  parameter int RELEASE_COUNT = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [10:0] distance_a, [21:11] distance_b, [22] button_pressed
  input  wire logic [23:0] s_axis_tdata,
  // [1:0] action
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] triggered, [1] emergency_flag, [2] obstacle_flag, [13:3] filtered_a,
  // [24:14] filtered_b, [25] sample_due
  output logic [31:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic                          s_acc;
  logic                          cfg_acc;
  logic [dsog_pkg::THR_W-1:0]    thr_q;
  logic [dsog_pkg::MS_W-1:0]     period_q;
  logic [dsog_pkg::MS_W-1:0]     warmup_q;
  dsog_pkg::lane_ctl_t           lane_ctl;
  dsog_pkg::lane_res_t           res_a, res_b;
  dsog_pkg::flags_t              flags;
  dsog_pkg::action_e             action;
  logic [dsog_pkg::DIST_W-1:0]   filt_a, filt_b;
  logic                          m_valid_q, m_valid_d;
  logic [31:0]                   m_data_q;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign action        = dsog_pkg::action_e'(s_axis_tuser);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= dsog_pkg::THR_RESET;
      period_q <= dsog_pkg::PERIOD_RESET;
      warmup_q <= dsog_pkg::WARMUP_RESET;
    end else if (cfg_acc) begin
      case (dsog_pkg::cfg_reg_e'(cfg_index_i))
        dsog_pkg::REG_THRESHOLD: thr_q    <= cfg_data_i[dsog_pkg::THR_W-1:0];
        dsog_pkg::REG_PERIOD:    period_q <= cfg_data_i;
        dsog_pkg::REG_WARMUP:    warmup_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dsog_lane u_lane_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lane_ctl),
    .dist_i (s_axis_tdata[10:0]),
    .thr_i  (thr_q),
    .res_o  (res_a)
  );

  dsog_lane u_lane_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lane_ctl),
    .dist_i (s_axis_tdata[21:11]),
    .thr_i  (thr_q),
    .res_o  (res_b)
  );

  dsog_ctrl #(
    .TRIGGER_COUNT (TRIGGER_COUNT),
    .RELEASE_COUNT (RELEASE_COUNT)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (s_acc),
    .action_i     (action),
    .button_i     (s_axis_tdata[22]),
    .near_new_i   (res_a.near_new || res_b.near_new),
    .near_last_i  (res_a.near_last || res_b.near_last),
    .period_cfg_i (period_q),
    .warmup_cfg_i (warmup_q),
    .ctl_o        (lane_ctl),
    .flags_o      (flags)
  );

  assign filt_a = lane_ctl.wr ? res_a.filt_new : res_a.filt_q;
  assign filt_b = lane_ctl.wr ? res_b.filt_new : res_b.filt_q;

  always_comb begin
    m_valid_d = m_valid_q;
    if (s_acc) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      m_data_q <= {6'd0, flags.sample_due, filt_b, filt_a,
                   flags.obstacle, flags.emergency, flags.triggered};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `ASSERT_CLK(a_stop_matches_causes, clk_i, rst_ni,
    m_valid_q |-> (m_data_q[0] == (m_data_q[1] || m_data_q[2])),
    "stop flag disagrees with emergency and obstacle")
  `ASSERT_CLK(a_accept_gives_result, clk_i, rst_ni,
    s_acc |=> m_valid_q, "accepted word produced no result")
  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
    s_acc && m_valid_q && !m_axis_tready, "pending result overwritten")
  `ASSERT_NEVER(a_slot_range, clk_i, rst_ni,
    lane_ctl.slot == 2'd3, "history slot out of range")

endmodule

`default_nettype wire
